/* rtl/core/fcsp_pkg.sv */
// Shared types and constants for the container stream parser.
package fcsp_pkg;

  // Result codes carried on event_kind
  typedef enum logic [1:0] {
    EV_HDR_OK  = 2'd0,
    EV_HDR_BAD = 2'd1,
    EV_PAYLOAD = 2'd2,
    EV_END     = 2'd3
  } fcsp_ev_t;

  // Header signature and length limits
  localparam logic [7:0]  SIG_F        = 8'h46;
  localparam logic [7:0]  SIG_L        = 8'h4C;
  localparam logic [7:0]  SIG_V        = 8'h56;
  localparam logic [31:0] HDR_MIN_LEN  = 32'd9;
  localparam logic [3:0]  HDR_LAST_IDX = 4'd8;

  // Tag framing
  localparam logic [7:0] TAG_AUDIO     = 8'd8;
  localparam logic [7:0] TAG_VIDEO     = 8'd9;
  localparam logic [7:0] TAG_SCRIPT    = 8'd18;
  localparam logic [3:0] TAGHDR_LAST   = 4'd10;
  localparam logic [1:0] PREV_LAST     = 2'd3;

  // Classified word passed from front to back
  typedef struct packed {
    fcsp_ev_t    kind;
    logic [7:0]  value;    // payload byte or header version
    logic        flag_a;   // first_of_tag or audio flag
    logic        flag_b;   // last_of_tag or video flag
    logic [7:0]  ttype;
    logic [23:0] tsize;
    logic [23:0] ttime;
    logic [7:0]  lead;     // first payload byte of the tag
  } fcsp_rec_t;

  // Queue status seen by the stall logic, the back and the checks
  typedef struct packed {
    logic full;
    logic empty;
  } fcsp_qstat_t;

endpackage

/* rtl/core/fcsp_front.sv */
// Front end: byte-level container parser that classifies each word.
module fcsp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  output logic              push,
  output fcsp_pkg::fcsp_rec_t rec
);
  import fcsp_pkg::*;

  typedef enum logic [2:0] {
    M_HEADER, M_SKIP, M_PREV, M_TAGHDR, M_PAYLOAD, M_DONE, M_ERROR
  } mode_t;

  mode_t       mode;
  logic [31:0] counter;
  logic [23:0] hdr_acc;
  logic [31:0] header_size;
  logic [7:0]  cur_type;
  logic [23:0] cur_size;
  logic [23:0] cur_time;
  logic [7:0]  version;
  logic        audio_en;
  logic        video_en;
  logic        drop;
  logic        sig_ok;
  logic [7:0]  lead_byte;

  logic [31:0] hdr_len;
  logic        hdr_bad;
  logic [32:0] count_inc;
  logic        skip_done;
  logic        pay_first;
  logic        pay_last;

  // Shared compares
  assign hdr_len   = {hdr_acc, data_byte};
  assign hdr_bad   = !sig_ok || (hdr_len < HDR_MIN_LEN);
  assign count_inc = {1'b0, counter} + 33'd1;
  assign skip_done = count_inc >= {1'b0, header_size};
  assign pay_first = (counter == 32'd0);
  assign pay_last  = count_inc >= {9'd0, cur_size};

  // Advance the parse state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_HEADER;
      counter     <= '0;
      hdr_acc     <= '0;
      header_size <= '0;
      cur_type    <= '0;
      cur_size    <= '0;
      cur_time    <= '0;
      version     <= '0;
      audio_en    <= 1'b0;
      video_en    <= 1'b0;
      drop        <= 1'b0;
      sig_ok      <= 1'b0;
      lead_byte   <= '0;
    end else if (take) begin
      if (end_of_stream) begin
        mode <= M_DONE;
      end else begin
        unique case (mode)
          M_HEADER: begin
            case (counter[3:0])
              4'd0: sig_ok <= (data_byte == SIG_F);
              4'd1: sig_ok <= sig_ok && (data_byte == SIG_L);
              4'd2: sig_ok <= sig_ok && (data_byte == SIG_V);
              4'd3: version <= data_byte;
              4'd4: begin
                audio_en <= data_byte[2];
                video_en <= data_byte[0];
              end
              default: hdr_acc <= {hdr_acc[15:0], data_byte};
            endcase
            if (counter[3:0] != HDR_LAST_IDX) begin
              counter <= count_inc[31:0];
            end else begin
              header_size <= hdr_len;
              if (hdr_bad) begin
                mode <= M_ERROR;
              end else if (hdr_len > HDR_MIN_LEN) begin
                mode    <= M_SKIP;
                counter <= HDR_MIN_LEN;
              end else begin
                mode    <= M_PREV;
                counter <= '0;
              end
            end
          end
          M_SKIP: begin
            if (skip_done) begin
              counter <= '0;
              mode    <= M_PREV;
            end else begin
              counter <= count_inc[31:0];
            end
          end
          M_PREV: begin
            if (counter[1:0] == PREV_LAST) begin
              counter  <= '0;
              cur_size <= '0;
              cur_time <= '0;
              mode     <= M_TAGHDR;
            end else begin
              counter <= count_inc[31:0];
            end
          end
          M_TAGHDR: begin
            if (counter[3:0] == 4'd0) begin
              cur_type <= data_byte;
            end else if (counter[3:0] <= 4'd3) begin
              cur_size <= {cur_size[15:0], data_byte};
            end else if (counter[3:0] <= 4'd6) begin
              cur_time <= {cur_time[15:0], data_byte};
            end
            if (counter[3:0] != TAGHDR_LAST) begin
              counter <= count_inc[31:0];
            end else begin
              // Drop unknown tags and the first tag of an undeclared kind
              if (cur_type == TAG_AUDIO) begin
                drop     <= !audio_en;
                audio_en <= 1'b1;
              end else if (cur_type == TAG_VIDEO) begin
                drop     <= !video_en;
                video_en <= 1'b1;
              end else begin
                drop <= (cur_type != TAG_SCRIPT);
              end
              counter <= '0;
              mode    <= (cur_size == 24'd0) ? M_PREV : M_PAYLOAD;
            end
          end
          M_PAYLOAD: begin
            if (pay_first) begin
              lead_byte <= data_byte;
            end
            if (pay_last) begin
              counter <= '0;
              mode    <= M_PREV;
            end else begin
              counter <= count_inc[31:0];
            end
          end
          M_DONE, M_ERROR: begin
            counter <= counter;
          end
          default: mode <= M_ERROR;
        endcase
      end
    end
  end

  // Classify the word into a queue record
  always_comb begin
    push = 1'b0;
    rec  = '0;
    if (take) begin
      if (end_of_stream) begin
        push     = 1'b1;
        rec.kind = EV_END;
      end else if (mode == M_HEADER && counter[3:0] == HDR_LAST_IDX) begin
        push       = 1'b1;
        rec.kind   = hdr_bad ? EV_HDR_BAD : EV_HDR_OK;
        rec.value  = version;
        rec.flag_a = audio_en;
        rec.flag_b = video_en;
      end else if (mode == M_PAYLOAD && !drop) begin
        push       = 1'b1;
        rec.kind   = EV_PAYLOAD;
        rec.value  = data_byte;
        rec.flag_a = pay_first;
        rec.flag_b = pay_last;
        rec.ttype  = cur_type;
        rec.tsize  = cur_size;
        rec.ttime  = cur_time;
        rec.lead   = pay_first ? data_byte : lead_byte;
      end
    end
  end

endmodule

/* rtl/core/fcsp_queue.sv */
// Small first-in first-out queue between the parser front and back.
module fcsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fcsp_pkg::fcsp_rec_t rec_in,
  input  logic                pop,
  output fcsp_pkg::fcsp_rec_t rec_out,
  output fcsp_pkg::fcsp_qstat_t status
);
  import fcsp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  fcsp_rec_t     slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= rec_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign rec_out      = slots[rd_ptr];
  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);

endmodule

/* rtl/core/fcsp_back.sv */
// Back end: expands queued words into result fields behind an output register.
module fcsp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fcsp_pkg::fcsp_rec_t  rec,
  input  fcsp_pkg::fcsp_qstat_t status,
  output logic                 pop,
  output logic                 event_valid,
  input  logic                 event_stall,
  output logic [1:0]           event_kind,
  output logic [7:0]           tag_kind,
  output logic [23:0]          tag_length,
  output logic [23:0]          tag_time,
  output logic                 first_of_tag,
  output logic                 last_of_tag,
  output logic [7:0]           payload_value,
  output logic [3:0]           upper_nibble,
  output logic [3:0]           lower_nibble,
  output logic [7:0]           stream_version,
  output logic                 audio_present,
  output logic                 video_present
);
  import fcsp_pkg::*;

  // Load a new word when the output slot is free or being taken
  assign pop = !status.empty && (!event_valid || !event_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (pop) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  // Decode the word by kind; fields that do not apply read zero
  always_ff @(posedge clk) begin
    if (pop) begin
      event_kind <= rec.kind;
      unique case (rec.kind)
        EV_HDR_OK, EV_HDR_BAD: begin
          tag_kind       <= '0;
          tag_length     <= '0;
          tag_time       <= '0;
          first_of_tag   <= 1'b0;
          last_of_tag    <= 1'b0;
          payload_value  <= '0;
          upper_nibble   <= '0;
          lower_nibble   <= '0;
          stream_version <= rec.value;
          audio_present  <= rec.flag_a;
          video_present  <= rec.flag_b;
        end
        EV_PAYLOAD: begin
          tag_kind       <= rec.ttype;
          tag_length     <= rec.tsize;
          tag_time       <= rec.ttime;
          first_of_tag   <= rec.flag_a;
          last_of_tag    <= rec.flag_b;
          payload_value  <= rec.value;
          upper_nibble   <= rec.lead[7:4];
          lower_nibble   <= rec.lead[3:0];
          stream_version <= '0;
          audio_present  <= 1'b0;
          video_present  <= 1'b0;
        end
        default: begin
          tag_kind       <= '0;
          tag_length     <= '0;
          tag_time       <= '0;
          first_of_tag   <= 1'b0;
          last_of_tag    <= 1'b0;
          payload_value  <= '0;
          upper_nibble   <= '0;
          lower_nibble   <= '0;
          stream_version <= '0;
          audio_present  <= 1'b0;
          video_present  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/core/flv_container_stream_parser_unit.sv */
// Top level of the container stream parser: front, word queue, back.
// Takes one stream byte per cycle while the word queue is not full, and gives at
// most one result per byte: a header verdict on the ninth header byte, one result
// per passed payload byte, and an end result per end marker. A result passes
// through the word queue and then the output register. The front stalls only
// when the QUEUE_DEPTH-entry word queue is full, which happens only while the
// result side holds off. Other header bytes, tag framing and previous-size words
// are consumed without results. A bad header leaves the block ignoring data
// until reset; an end marker is honored in every state.
module flv_container_stream_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic [7:0]  tag_kind,
  output logic [23:0] tag_length,
  output logic [23:0] tag_time,
  output logic        first_of_tag,
  output logic        last_of_tag,
  output logic [7:0]  payload_value,
  output logic [3:0]  upper_nibble,
  output logic [3:0]  lower_nibble,
  output logic [7:0]  stream_version,
  output logic        audio_present,
  output logic        video_present
);
  import fcsp_pkg::*;

  logic        take;
  logic        push;
  logic        pop;
  fcsp_rec_t   rec_in;
  fcsp_rec_t   rec_out;
  fcsp_qstat_t qstat;

  // Hold the byte side off while the queue is full
  assign data_stall = qstat.full;
  assign take       = data_valid && !data_stall;

  fcsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .push          (push),
    .rec           (rec_in)
  );

  fcsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rec_in  (rec_in),
    .pop     (pop),
    .rec_out (rec_out),
    .status  (qstat)
  );

  fcsp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .rec            (rec_out),
    .status         (qstat),
    .pop            (pop),
    .event_valid    (event_valid),
    .event_stall    (event_stall),
    .event_kind     (event_kind),
    .tag_kind       (tag_kind),
    .tag_length     (tag_length),
    .tag_time       (tag_time),
    .first_of_tag   (first_of_tag),
    .last_of_tag    (last_of_tag),
    .payload_value  (payload_value),
    .upper_nibble   (upper_nibble),
    .lower_nibble   (lower_nibble),
    .stream_version (stream_version),
    .audio_present  (audio_present),
    .video_present  (video_present)
  );

  // An end marker always reaches the queue
  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    take && end_of_stream |=> !qstat.empty)
    else $error("end marker not queued");

  // Queue never pushes while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("push into full queue");

  // Tag position flags only on payload results
  a_flags_payload: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind != EV_PAYLOAD) |-> !first_of_tag && !last_of_tag)
    else $error("tag flags on non-payload result");

  // Header fields only on header results
  a_hdr_fields: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == EV_PAYLOAD || event_kind == EV_END)
      |-> stream_version == 8'd0 && !audio_present && !video_present)
    else $error("header fields on non-header result");

endmodule
